@@ hdl/rrpt_pkg.sv @@
`default_nettype none

package rrpt_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [2:0]        t_func;
    typedef logic [1:0]        t_code;

    typedef enum logic [1:0] {
        ST_TERM  = 2'd0,
        ST_READY = 2'd1,
        ST_EXEC  = 2'd2
    } t_status;

    localparam t_func FN_SCHED  = 3'd0;
    localparam t_func FN_FORK   = 3'd1;
    localparam t_func FN_EXIT   = 3'd2;
    localparam t_func FN_KILL   = 3'd3;
    localparam t_func FN_GETPID = 3'd4;

    localparam t_code CODE_OK        = 2'd0;
    localparam t_code CODE_KILL_DEAD = 2'd1;
    localparam t_code CODE_FULL      = 2'd2;

    typedef struct packed {
        logic    en;
        t_slot   addr;
        t_status data;
    } t_tbl_wr;

    function automatic logic slot_live(input t_status s);
        return (s == ST_READY) || (s == ST_EXEC);
    endfunction

endpackage

`default_nettype wire

@@ hdl/rrpt_if.sv @@
`default_nettype none

interface rrpt_in_if;
    logic           valid;
    logic           ready;
    logic [2:0]     func;
    logic [4:0]     target_slot;

    modport source (output valid, output func, output target_slot, input ready);
    modport sink   (input valid, input func, input target_slot, output ready);
endinterface

interface rrpt_out_if;
    logic           valid;
    logic           ready;
    logic [4:0]     active_slot;
    logic [4:0]     result_slot;
    logic [1:0]     status_code;

    modport source (output valid, output active_slot, output result_slot,
                    output status_code, input ready);
    modport sink   (input valid, input active_slot, input result_slot,
                    input status_code, output ready);
endinterface

`default_nettype wire

@@ hdl/rrpt_slot_table.sv @@
`default_nettype none

module rrpt_slot_table (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rrpt_pkg::t_slot     i_rd_addr,
    output rrpt_pkg::t_status   o_rd_data,
    input  rrpt_pkg::t_tbl_wr   i_wr
);

    rrpt_pkg::t_status r_status [rrpt_pkg::NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status[0] <= rrpt_pkg::ST_EXEC;
            for (int i = 1; i < rrpt_pkg::NUM_SLOTS; i++) begin
                r_status[i] <= rrpt_pkg::ST_TERM;
            end
        end else if (i_wr.en) begin
            r_status[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_status[i_rd_addr];

endmodule

`default_nettype wire

@@ hdl/round_robin_process_table_unit.sv @@
// getpid, unknown codes and a schedule with one live program go straight to the result;
// a kill first checks its target and ends there if rejected; schedule, fork, exit and kill
// scan one slot per cycle; one word at a time: the input is ready again as soon as the
// result is in the output register; reset: slot 0 executing, all other slots terminated,
// current and highest slot 0, live count 1; the input is ready from the first cycle after
// reset
`default_nettype none

module round_robin_process_table_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rrpt_in_if.sink     i_in,
    rrpt_out_if.source  o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KILL_CHK,
        S_EXIT,
        S_FSCAN,
        S_FLEAVE,
        S_FENTER,
        S_SW_SCAN,
        S_SW_LEAVE,
        S_SW_ENTER,
        S_DONE
    } t_state;

    t_state              r_state;
    rrpt_pkg::t_slot     r_target;
    rrpt_pkg::t_slot     r_cur;
    rrpt_pkg::t_slot     r_high;
    rrpt_pkg::t_cnt      r_live;
    rrpt_pkg::t_cnt      r_idx;
    rrpt_pkg::t_slot     r_next;
    rrpt_pkg::t_slot     r_result;
    rrpt_pkg::t_code     r_code;
    logic                r_out_valid;
    rrpt_pkg::t_slot     r_out_act;
    rrpt_pkg::t_slot     r_out_res;
    rrpt_pkg::t_code     r_out_code;

    rrpt_pkg::t_slot     rd_addr;
    rrpt_pkg::t_status   rd_data;
    rrpt_pkg::t_tbl_wr   tbl_wr;
    rrpt_pkg::t_cnt      cur_plus;
    rrpt_pkg::t_cnt      high_plus;
    rrpt_pkg::t_cnt      live_dec;
    logic                idx_past;
    logic                rd_live;

    rrpt_slot_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (tbl_wr)
    );

    assign cur_plus  = {1'b0, r_cur} + rrpt_pkg::CNT_W'(1);
    assign high_plus = {1'b0, r_high} + rrpt_pkg::CNT_W'(1);
    assign live_dec  = (r_live > rrpt_pkg::CNT_W'(1)) ? r_live - rrpt_pkg::CNT_W'(1)
                                                      : rrpt_pkg::CNT_W'(1);
    assign idx_past  = r_idx > {1'b0, r_high};
    assign rd_live   = rrpt_pkg::slot_live(rd_data);

    // single read port of the table
    always_comb begin
        unique case (r_state)
            S_FSCAN, S_SW_SCAN: rd_addr = r_idx[rrpt_pkg::SLOT_W-1:0];
            S_KILL_CHK:         rd_addr = r_target;
            default:            rd_addr = r_cur;
        endcase
    end

    // single write port of the table
    always_comb begin
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = r_cur;
        tbl_wr.data = rrpt_pkg::ST_TERM;
        unique case (r_state)
            S_KILL_CHK: begin
                tbl_wr.en   = (r_target != '0) && rd_live;
                tbl_wr.addr = r_target;
            end
            S_EXIT: begin
                tbl_wr.en = (r_cur != '0);
            end
            S_FLEAVE: begin
                tbl_wr.en   = rd_live;
                tbl_wr.data = rrpt_pkg::ST_READY;
            end
            S_SW_LEAVE: begin
                tbl_wr.en   = (rd_data == rrpt_pkg::ST_EXEC);
                tbl_wr.data = rrpt_pkg::ST_READY;
            end
            S_FENTER, S_SW_ENTER: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = r_next;
                tbl_wr.data = rrpt_pkg::ST_EXEC;
            end
            default: begin
                tbl_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_cur       <= '0;
            r_high      <= '0;
            r_live      <= rrpt_pkg::CNT_W'(1);
            r_idx       <= '0;
            r_next      <= '0;
            r_result    <= '0;
            r_code      <= rrpt_pkg::CODE_OK;
            r_out_valid <= 1'b0;
            r_out_act   <= '0;
            r_out_res   <= '0;
            r_out_code  <= rrpt_pkg::CODE_OK;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_target <= i_in.target_slot;
                        r_result <= (i_in.func == rrpt_pkg::FN_GETPID) ? r_cur : '0;
                        r_code   <= rrpt_pkg::CODE_OK;
                        r_idx    <= (i_in.func == rrpt_pkg::FN_FORK) ? rrpt_pkg::CNT_W'(1)
                                                                     : cur_plus;
                        case (i_in.func)
                            rrpt_pkg::FN_SCHED: begin
                                r_state <= (r_live > rrpt_pkg::CNT_W'(1)) ? S_SW_SCAN
                                                                         : S_DONE;
                            end
                            rrpt_pkg::FN_FORK:   r_state <= S_FSCAN;
                            rrpt_pkg::FN_EXIT:   r_state <= S_EXIT;
                            rrpt_pkg::FN_KILL:   r_state <= S_KILL_CHK;
                            rrpt_pkg::FN_GETPID: r_state <= S_DONE;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_EXIT: begin
                    if (r_cur != '0) begin
                        r_live <= live_dec;
                    end
                    r_state <= S_SW_SCAN;
                end
                S_KILL_CHK: begin
                    if ((r_target == '0) || !rd_live) begin
                        r_code  <= rrpt_pkg::CODE_KILL_DEAD;
                        r_state <= S_DONE;
                    end else begin
                        r_live  <= live_dec;
                        r_state <= S_SW_SCAN;
                    end
                end
                S_FSCAN: begin
                    if (idx_past) begin
                        if (high_plus < rrpt_pkg::CNT_W'(rrpt_pkg::NUM_SLOTS)) begin
                            r_high  <= high_plus[rrpt_pkg::SLOT_W-1:0];
                            r_next  <= high_plus[rrpt_pkg::SLOT_W-1:0];
                            r_state <= S_FLEAVE;
                        end else begin
                            r_code  <= rrpt_pkg::CODE_FULL;
                            r_state <= S_DONE;
                        end
                    end else if (!rd_live) begin
                        r_next  <= r_idx[rrpt_pkg::SLOT_W-1:0];
                        r_state <= S_FLEAVE;
                    end else begin
                        r_idx <= r_idx + rrpt_pkg::CNT_W'(1);
                    end
                end
                S_FLEAVE: begin
                    r_state <= S_FENTER;
                end
                S_FENTER: begin
                    r_cur    <= r_next;
                    r_live   <= r_live + rrpt_pkg::CNT_W'(1);
                    r_result <= r_next;
                    r_state  <= S_DONE;
                end
                S_SW_SCAN: begin
                    if (idx_past) begin
                        r_next  <= '0;
                        r_state <= S_SW_LEAVE;
                    end else if (rd_live) begin
                        r_next  <= r_idx[rrpt_pkg::SLOT_W-1:0];
                        r_state <= S_SW_LEAVE;
                    end else begin
                        r_idx <= r_idx + rrpt_pkg::CNT_W'(1);
                    end
                end
                S_SW_LEAVE: begin
                    r_state <= S_SW_ENTER;
                end
                S_SW_ENTER: begin
                    r_cur   <= r_next;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_act   <= r_cur;
                        r_out_res   <= r_result;
                        r_out_code  <= r_code;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.active_slot = r_out_act;
    assign o_out.result_slot = r_out_res;
    assign o_out.status_code = r_out_code;

endmodule

`default_nettype wire
